// ===== hdl/vrrm_pkg.sv =====
`timescale 1ns / 1ps

package vrrm_pkg;

   // Widths of the request and response fields
   localparam int FIELD_BITS = 16;
   localparam int MODE_BITS = 3;
   localparam int STATUS_BITS = 2;

   // Intermediate sums: line + header + payload + alignment never reach 2^18
   localparam int CALC_BITS = 18;

   localparam int DEFAULT_HEADER_BYTES = 4;
   localparam int DEFAULT_OFFSET_BITS = 16;

   // Register file
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUFFER_LEN = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_OFFSET = 1'd1;

   localparam logic [FIELD_BITS-1:0] RESET_BUFFER_LEN = 16'd4096;
   localparam logic RESET_START_OFFSET = 1'b0;

   // Request modes
   localparam logic [MODE_BITS-1:0] MODE_ENQ_BEGIN = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_ENQ_END = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_ENQ_ABORT = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_DEQ_BEGIN = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_DEQ_END = 3'd4;

   // Response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY_BUSY = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_ORDER = 2'd3;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [FIELD_BITS-1:0] line_length;
      logic [FIELD_BITS-1:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [FIELD_BITS-1:0] entry_offset;
      logic [FIELD_BITS-1:0] payload_offset;
      logic [FIELD_BITS-1:0] payload_capacity;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] buffer_len;
      logic start_offset;
   } cfg_type;

endpackage

// ===== hdl/vrrm_csr.sv =====
`timescale 1ns / 1ps

module vrrm_csr import vrrm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BUFFER_LEN: cfg_in.buffer_len = csr_data;
            CSR_START_OFFSET: cfg_in.start_offset = csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_len <= RESET_BUFFER_LEN;
         cfg_ff.start_offset <= RESET_START_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/vrrm_core.sv =====
`timescale 1ns / 1ps

module vrrm_core import vrrm_pkg::*; #(
   parameter int HEADER_BYTES = DEFAULT_HEADER_BYTES,
   parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  req_type in_data,
   input  cfg_type cfg,
   output logic out_strobe,
   output rsp_type out_data
);

   typedef logic [OFFSET_BITS-1:0] pos_type;
   typedef logic [CALC_BITS-1:0] calc_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   // Ring state
   pos_type rd_pos_ff, rd_pos_in;
   pos_type wr_pos_ff, wr_pos_in;
   pos_type wrap_pos_ff, wrap_pos_in;
   logic wrapped_ff, wrapped_in;
   field_type used_ff, used_in;
   pos_type open_entry_ff, open_entry_in;
   field_type open_line_ff, open_line_in;
   field_type open_cap_ff, open_cap_in;
   logic enq_open_ff, enq_open_in;
   logic deq_open_ff, deq_open_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;

   pos_type start_pos, buf_pos;
   calc_type hdr;

   // Enqueue begin
   calc_type eb_size;
   field_type eb_free;
   logic eb_fit, eb_rewind;
   pos_type eb_rd, eb_wr, eb_wrap;
   logic eb_wrapped;
   pos_type eb_room, eb_head;
   field_type eb_tail;
   logic eb_fits_tail, eb_fits_head, eb_wrap_now, eb_ok;
   pos_type eb_at, eb_new_wr;
   field_type eb_seg_end, eb_cap;

   // Enqueue end and abort
   calc_type ee_prefix, ee_align, ee_add0, ee_add1, ee_add;
   logic ee_over;

   // Dequeue end
   calc_type de_raw, de_align, de_tot;
   field_type de_seg_end, de_used;
   pos_type de_rd;

   assign start_pos = OFFSET_BITS'(cfg.start_offset);
   assign buf_pos = OFFSET_BITS'(cfg.buffer_len);
   assign hdr = CALC_BITS'(HEADER_BYTES);

   // Reserve header, line and terminator
   assign eb_size = hdr + CALC_BITS'(in_data.line_length) + calc_type'(1);
   assign eb_free = (cfg.buffer_len > used_ff) ? cfg.buffer_len - used_ff : '0;
   assign eb_fit = eb_size <= CALC_BITS'(eb_free);
   assign eb_rewind = (used_ff == '0);
   assign eb_rd = eb_rewind ? start_pos : rd_pos_ff;
   assign eb_wr = eb_rewind ? start_pos : wr_pos_ff;
   assign eb_wrap = eb_rewind ? buf_pos : wrap_pos_ff;
   assign eb_wrapped = eb_rewind ? 1'b0 : wrapped_ff;
   assign eb_room = (eb_rd > eb_wr) ? eb_rd - eb_wr : '0;
   assign eb_tail = (cfg.buffer_len > FIELD_BITS'(eb_wr)) ?
                    cfg.buffer_len - FIELD_BITS'(eb_wr) : '0;
   assign eb_head = (eb_rd > start_pos) ? eb_rd - start_pos : '0;
   assign eb_fits_tail = eb_size <= CALC_BITS'(eb_tail);
   assign eb_fits_head = eb_size <= CALC_BITS'(eb_head);
   // Wrap when the head gap fits and is larger, or when it is the only gap that fits
   assign eb_wrap_now = !eb_wrapped && eb_fits_head &&
                        ((FIELD_BITS'(eb_head) > eb_tail) || !eb_fits_tail);
   assign eb_ok = eb_wrapped ? (eb_size <= CALC_BITS'(eb_room))
                             : (eb_fits_tail || eb_fits_head);
   assign eb_at = eb_wrap_now ? start_pos : eb_wr;
   assign eb_new_wr = OFFSET_BITS'(CALC_BITS'(eb_at) + eb_size);
   assign eb_seg_end = (eb_wrapped || eb_wrap_now) ? FIELD_BITS'(eb_rd) : cfg.buffer_len;
   assign eb_cap = (eb_seg_end > FIELD_BITS'(eb_new_wr)) ?
                   eb_seg_end - FIELD_BITS'(eb_new_wr) : '0;

   // Payload with 2-byte alignment of the whole record
   assign ee_prefix = hdr + CALC_BITS'(open_line_ff) + calc_type'(1);
   assign ee_align = (ee_prefix + CALC_BITS'(in_data.payload_length) + calc_type'(1))
                     & ~calc_type'(1);
   assign ee_add0 = ee_align - ee_prefix;
   assign ee_add1 = (ee_add0 > CALC_BITS'(open_cap_ff)) ?
                    CALC_BITS'(in_data.payload_length) : ee_add0;
   assign ee_over = ee_add1 > CALC_BITS'(open_cap_ff);
   assign ee_add = ee_over ? CALC_BITS'(open_cap_ff) : ee_add1;

   // Release: drop the alignment pad when it would cross the segment end
   assign de_raw = hdr + CALC_BITS'(in_data.line_length) + calc_type'(1)
                   + CALC_BITS'(in_data.payload_length);
   assign de_align = (de_raw + calc_type'(1)) & ~calc_type'(1);
   assign de_seg_end = wrapped_ff ? FIELD_BITS'(wrap_pos_ff) : cfg.buffer_len;
   assign de_tot = ((CALC_BITS'(rd_pos_ff) + de_align) > CALC_BITS'(de_seg_end)) ?
                   de_raw : de_align;
   assign de_rd = OFFSET_BITS'(CALC_BITS'(rd_pos_ff) + de_tot);
   assign de_used = (CALC_BITS'(used_ff) > de_tot) ?
                    FIELD_BITS'(CALC_BITS'(used_ff) - de_tot) : '0;

   always_comb begin
      rd_pos_in = rd_pos_ff;
      wr_pos_in = wr_pos_ff;
      wrap_pos_in = wrap_pos_ff;
      wrapped_in = wrapped_ff;
      used_in = used_ff;
      open_entry_in = open_entry_ff;
      open_line_in = open_line_ff;
      open_cap_in = open_cap_ff;
      enq_open_in = enq_open_ff;
      deq_open_in = deq_open_ff;
      rsp_strobe_in = in_valid;
      rsp_data_in.status = STATUS_ORDER;
      rsp_data_in.entry_offset = '0;
      rsp_data_in.payload_offset = '0;
      rsp_data_in.payload_capacity = '0;

      if (in_valid) begin
         unique case (in_data.mode)
            MODE_ENQ_BEGIN: begin
               if (!enq_open_ff) begin
                  if (!eb_fit) begin
                     rsp_data_in.status = STATUS_NO_SPACE;
                  end else begin
                     // Empty ring rewinds even when the placement then fails
                     rd_pos_in = eb_rd;
                     wr_pos_in = eb_wr;
                     wrap_pos_in = eb_wrap;
                     wrapped_in = eb_wrapped;
                     if (!eb_ok) begin
                        rsp_data_in.status = STATUS_NO_SPACE;
                     end else begin
                        if (eb_wrap_now) begin
                           wrap_pos_in = eb_wr;
                           wrapped_in = 1'b1;
                        end
                        wr_pos_in = eb_new_wr;
                        used_in = FIELD_BITS'(CALC_BITS'(used_ff) + eb_size);
                        open_cap_in = eb_cap;
                        open_entry_in = eb_at;
                        open_line_in = in_data.line_length;
                        enq_open_in = 1'b1;
                        rsp_data_in.status = STATUS_OK;
                        rsp_data_in.entry_offset = FIELD_BITS'(eb_at);
                        rsp_data_in.payload_offset =
                           FIELD_BITS'(CALC_BITS'(eb_at) + eb_size);
                        rsp_data_in.payload_capacity = eb_cap;
                     end
                  end
               end
            end
            MODE_ENQ_END: begin
               if (enq_open_ff) begin
                  wr_pos_in = OFFSET_BITS'(CALC_BITS'(wr_pos_ff) + ee_add);
                  used_in = FIELD_BITS'(CALC_BITS'(used_ff) + ee_add);
                  open_cap_in = '0;
                  enq_open_in = 1'b0;
                  rsp_data_in.status = ee_over ? STATUS_NO_SPACE : STATUS_OK;
                  rsp_data_in.entry_offset = FIELD_BITS'(open_entry_ff);
                  rsp_data_in.payload_offset =
                     FIELD_BITS'(CALC_BITS'(open_entry_ff) + ee_prefix);
               end
            end
            MODE_ENQ_ABORT: begin
               if (enq_open_ff) begin
                  used_in = (CALC_BITS'(used_ff) > ee_prefix) ?
                            FIELD_BITS'(CALC_BITS'(used_ff) - ee_prefix) : '0;
                  // Undo the wrap this reservation caused
                  if (open_entry_ff == start_pos && wrapped_ff) begin
                     wr_pos_in = wrap_pos_ff;
                     wrap_pos_in = buf_pos;
                     wrapped_in = 1'b0;
                  end else begin
                     wr_pos_in = open_entry_ff;
                  end
                  open_cap_in = '0;
                  enq_open_in = 1'b0;
                  rsp_data_in.status = STATUS_OK;
                  rsp_data_in.entry_offset = FIELD_BITS'(open_entry_ff);
                  rsp_data_in.payload_offset =
                     FIELD_BITS'(CALC_BITS'(open_entry_ff) + ee_prefix);
               end
            end
            MODE_DEQ_BEGIN: begin
               if (deq_open_ff || enq_open_ff || used_ff == '0) begin
                  rsp_data_in.status = STATUS_EMPTY_BUSY;
               end else begin
                  deq_open_in = 1'b1;
                  rsp_data_in.status = STATUS_OK;
                  rsp_data_in.entry_offset = FIELD_BITS'(rd_pos_ff);
               end
            end
            MODE_DEQ_END: begin
               if (deq_open_ff) begin
                  rd_pos_in = de_rd;
                  used_in = de_used;
                  if (wrapped_ff && de_rd == wrap_pos_ff) begin
                     rd_pos_in = start_pos;
                     wrap_pos_in = buf_pos;
                     wrapped_in = 1'b0;
                  end
                  if (de_used == '0) begin
                     rd_pos_in = start_pos;
                     wr_pos_in = start_pos;
                     wrap_pos_in = buf_pos;
                     wrapped_in = 1'b0;
                  end
                  deq_open_in = 1'b0;
                  rsp_data_in.status = STATUS_OK;
                  rsp_data_in.entry_offset = FIELD_BITS'(rd_pos_ff);
                  rsp_data_in.payload_offset = FIELD_BITS'(CALC_BITS'(rd_pos_ff) + hdr
                     + CALC_BITS'(in_data.line_length) + calc_type'(1));
               end
            end
            default: begin
               rsp_data_in.status = STATUS_ORDER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff <= OFFSET_BITS'(RESET_START_OFFSET);
         wr_pos_ff <= OFFSET_BITS'(RESET_START_OFFSET);
         wrap_pos_ff <= OFFSET_BITS'(RESET_BUFFER_LEN);
         wrapped_ff <= 1'b0;
         used_ff <= '0;
         open_entry_ff <= '0;
         open_line_ff <= '0;
         open_cap_ff <= '0;
         enq_open_ff <= 1'b0;
         deq_open_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_pos_ff <= rd_pos_in;
         wr_pos_ff <= wr_pos_in;
         wrap_pos_ff <= wrap_pos_in;
         wrapped_ff <= wrapped_in;
         used_ff <= used_in;
         open_entry_ff <= open_entry_in;
         open_line_ff <= open_line_in;
         open_cap_ff <= open_cap_in;
         enq_open_ff <= enq_open_in;
         deq_open_ff <= deq_open_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign out_strobe = rsp_strobe_ff;
   assign out_data = rsp_data_ff;

endmodule

// ===== hdl/variable_record_ring_manager.sv =====
`timescale 1ns / 1ps

// Offset manager for a ring of variable-length records (bip buffer).
// Request channel: a request (req_data: mode, line_length, payload_length)
// is taken at a rising edge with start high and busy low. busy stays low,
// so a request can be issued every cycle.
// Response channel: rsp_strobe marks rsp_data (status, entry_offset,
// payload_offset, payload_capacity) for exactly one cycle. The receiver
// cannot stall; every request yields exactly one response.
// The response is registered: a request passes the input register, one
// pass of pointer arithmetic and the response register. Throughput: one
// request per cycle; the pointer registers are updated for each request
// before the next one reaches the pointer arithmetic.
// Register port: csr_write, csr_index, csr_data; index 0 is buffer_len,
// index 1 is start_offset. Write only when no request is in flight.
// Reset (synchronous, active high): buffer_len 4096, start_offset 0, ring
// empty with read and write positions at the start and the wrap position
// at buffer_len, no enqueue or dequeue open, no request in flight.
module variable_record_ring_manager import vrrm_pkg::*; #(
   parameter int HEADER_BYTES = DEFAULT_HEADER_BYTES,
   parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_strobe,
   output rsp_type rsp_data,
   input  logic csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic req_valid_ff, req_valid_in;
   req_type req_data_ff;
   cfg_type cfg;

   assign busy = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data;
   end

   vrrm_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   vrrm_core #(
      .HEADER_BYTES(HEADER_BYTES),
      .OFFSET_BITS(OFFSET_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid_ff),
      .in_data(req_data_ff),
      .cfg(cfg),
      .out_strobe(rsp_strobe),
      .out_data(rsp_data)
   );

endmodule

// ===== hdl/vrrm_checker.sv =====
`timescale 1ns / 1ps

module vrrm_checker import vrrm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic rsp_strobe,
   input  rsp_type rsp_data
);

   // One response for each request, through the input and response registers
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == ($past(start && !busy, 2) && !$past(reset, 2) && !$past(reset, 1)))
      else $error("response strobe does not match an accepted request");

   // Capacity is reported only for a successful reservation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STATUS_OK) |-> (rsp_data.payload_capacity == '0))
      else $error("capacity reported on a failed request");

   // Refused dequeue reports no record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_EMPTY_BUSY) |->
      (rsp_data.entry_offset == '0 && rsp_data.payload_offset == '0))
      else $error("offsets reported on an empty or busy dequeue");

   // Out-of-order request leaves every field clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_ORDER) |->
      (rsp_data.entry_offset == '0 && rsp_data.payload_offset == '0
       && rsp_data.payload_capacity == '0))
      else $error("fields set on an out-of-order request");

endmodule

bind variable_record_ring_manager vrrm_checker u_checker (.*);
